// ===== design/mode_coefficient_canonicalizer_core_defines.svh =====
// assertion macros for the mode coefficient canonicalizer
// included by modules that carry concurrent checks
`ifndef MODE_COEFFICIENT_CANONICALIZER_CORE_DEFINES_SVH
`define MODE_COEFFICIENT_CANONICALIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MCC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("check failed");
`define MCC_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) else $error("check failed");
`else
`define MCC_ASSERT(label, clk, rst_n, prop)
`define MCC_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== design/mcc_pkg.sv =====
// shared types, constants and functions of the mode coefficient canonicalizer
// no dependencies
package mcc_pkg;
	localparam int COEFF_BITS = 4;
	localparam int NMODES = 5;
	localparam int NCOEF = 10;
	localparam int NSYM = 64;
	localparam int NGROUP = NSYM / 8;
	localparam int GCD_BITS = COEFF_BITS - 1;
	localparam int CMAX = (1 << (COEFF_BITS - 1)) - 1;

	typedef logic signed [COEFF_BITS-1:0] coef_t;
	typedef coef_t [NCOEF-1:0] vec_t;
	typedef logic [GCD_BITS-1:0] mag_t;

	// per-mode phase weights and swap permutation
	localparam logic [1:0] MODE_KX [NMODES] = '{2'd1, 2'd0, 2'd1, 2'd2, 2'd1};
	localparam logic [1:0] MODE_KY [NMODES] = '{2'd0, 2'd1, 2'd1, 2'd1, 2'd2};
	localparam int MODE_PERM [NMODES] = '{1, 0, 2, 4, 3};

	// true when m is a whole multiple of the constant d
	function automatic logic is_multiple(input mag_t m, input int d);
		logic r;
		r = 1'b0;
		for (int k = 0; k <= CMAX; k++) begin
			if (k * d == int'(m)) r = 1'b1;
		end
		return r;
	endfunction

	function automatic mag_t gcd_small(input mag_t a, input mag_t b);
		mag_t g;
		g = '0;
		if (a == '0) begin
			g = b;
		end else if (b == '0) begin
			g = a;
		end else begin
			// largest candidate that divides both wins
			for (int d = 1; d <= CMAX; d++) begin
				if (is_multiple(a, d) && is_multiple(b, d)) g = mag_t'(d);
			end
		end
		return g;
	endfunction

	// quotient of m by g when g divides m exactly
	function automatic mag_t exact_quot(input mag_t m, input mag_t g);
		mag_t q;
		q = '0;
		for (int k = 0; k <= CMAX; k++) begin
			if (k * int'(g) == int'(m)) q = mag_t'(k);
		end
		return q;
	endfunction

	function automatic logic lex_less(input vec_t x, input vec_t y);
		logic done;
		logic r;
		done = 1'b0;
		r = 1'b0;
		for (int i = 0; i < NCOEF; i++) begin
			if (!done && x[i] != y[i]) begin
				done = 1'b1;
				r = x[i] < y[i];
			end
		end
		return r;
	endfunction

	function automatic vec_t apply_sym(input vec_t c, input logic [5:0] sym);
		vec_t o;
		logic [1:0] tx;
		logic [1:0] ty;
		logic cj;
		logic sw;
		logic [1:0] ph;
		int src;
		coef_t a;
		coef_t b;
		coef_t ar;
		coef_t br;
		tx = sym[5:4];
		ty = sym[3:2];
		cj = sym[1];
		sw = sym[0];
		for (int j = 0; j < NMODES; j++) begin
			src = sw ? MODE_PERM[j] : j;
			ph = 2'(tx * MODE_KX[j] + ty * MODE_KY[j]);
			a = c[2 * src];
			b = cj ? -c[2 * src + 1] : c[2 * src + 1];
			case (ph)
				2'd0: begin ar = a; br = b; end
				2'd1: begin ar = b; br = -a; end
				2'd2: begin ar = -a; br = -b; end
				default: begin ar = -b; br = a; end
			endcase
			if (sw) begin
				ar = -ar;
				br = -br;
			end
			o[2 * j] = ar;
			o[2 * j + 1] = br;
		end
		return o;
	endfunction
endpackage

// ===== design/mcc_norm.sv =====
// clamp, gcd and divide stages (three register stages)
// depends on mcc_pkg
module mcc_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  mcc_pkg::vec_t       raw,
	output logic                v_out,
	output mcc_pkg::vec_t       c_out,
	output mcc_pkg::vec_t       raw_out,
	output mcc_pkg::mag_t       g_out
);
	import mcc_pkg::*;

	logic v_s1, v_s2, v_s3;
	vec_t c_s1, raw_s1, c_s2, raw_s2, c_s3, raw_s3;
	mag_t mag_s1 [NCOEF];
	mag_t g_s2, g_s3;
	mag_t gpair [NCOEF/2];
	mag_t gtot;
	mag_t qmag [NCOEF];
	vec_t clamp;
	vec_t divd;

	always_comb begin
		for (int i = 0; i < NCOEF; i++) begin
			clamp[i] = (raw[i] < -coef_t'(CMAX)) ? -coef_t'(CMAX) : raw[i];
		end
	end

	always_comb begin
		for (int i = 0; i < NCOEF / 2; i++) gpair[i] = gcd_small(mag_s1[2*i], mag_s1[2*i+1]);
		gtot = gcd_small(gcd_small(gpair[0], gpair[1]),
			gcd_small(gcd_small(gpair[2], gpair[3]), gpair[4]));
	end

	// division is exact, so the quotient is the multiple of the gcd that matches
	always_comb begin
		for (int i = 0; i < NCOEF; i++) begin
			qmag[i] = exact_quot(mag_t'(c_s2[i] < 0 ? -c_s2[i] : c_s2[i]), g_s2);
			if (g_s2 > mag_t'(1)) begin
				divd[i] = (c_s2[i] < 0) ? -coef_t'({1'b0, qmag[i]}) : coef_t'({1'b0, qmag[i]});
			end else begin
				divd[i] = c_s2[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= clamp;
			raw_s1 <= raw;
			for (int i = 0; i < NCOEF; i++) begin
				mag_s1[i] <= mag_t'(clamp[i] < 0 ? -clamp[i] : clamp[i]);
			end
			c_s2 <= c_s1;
			raw_s2 <= raw_s1;
			g_s2 <= gtot;
			c_s3 <= divd;
			raw_s3 <= raw_s2;
			g_s3 <= g_s2;
		end
	end

	assign v_out = v_s3;
	assign c_out = c_s3;
	assign raw_out = raw_s3;
	assign g_out = g_s3;
endmodule

// ===== design/mcc_search.sv =====
// symmetry search: 64 candidates reduced over a registered tree
// depends on mcc_pkg
`include "mode_coefficient_canonicalizer_core_defines.svh"
module mcc_search (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  mcc_pkg::vec_t       c_in,
	input  mcc_pkg::vec_t       raw_in,
	input  mcc_pkg::mag_t       g_in,
	output logic                v_out,
	output mcc_pkg::vec_t       best_out,
	output mcc_pkg::mag_t       g_out,
	output logic                same_out
);
	import mcc_pkg::*;

	logic v_s4, v_s5, v_s6;
	vec_t cand_s4 [NSYM];
	vec_t best_s5 [NGROUP];
	vec_t best_s6;
	vec_t raw_s4, raw_s5, raw_s6;
	mag_t g_s4, g_s5, g_s6;
	vec_t red1 [NGROUP];
	vec_t red2;

	// eight-way minimum per group; identity is candidate 0
	always_comb begin
		for (int k = 0; k < NGROUP; k++) begin
			red1[k] = cand_s4[8*k];
			for (int i = 1; i < 8; i++) begin
				if (lex_less(cand_s4[8*k+i], red1[k])) red1[k] = cand_s4[8*k+i];
			end
		end
		red2 = best_s5[0];
		for (int k = 1; k < NGROUP; k++) begin
			if (lex_less(best_s5[k], red2)) red2 = best_s5[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_in;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < NSYM; s++) cand_s4[s] <= apply_sym(c_in, 6'(s));
			raw_s4 <= raw_in;
			g_s4 <= g_in;
			best_s5 <= red1;
			raw_s5 <= raw_s4;
			g_s5 <= g_s4;
			best_s6 <= red2;
			raw_s6 <= raw_s5;
			g_s6 <= g_s5;
		end
	end

	assign v_out = v_s6;
	assign best_out = best_s6;
	assign g_out = g_s6;
	assign same_out = (raw_s6 == best_s6);

	`MCC_ASSERT(a_best_not_above_id, clk, arst_n, !lex_less(cand_s4[0], red1[0]))
	`MCC_ASSERT(a_final_min, clk, arst_n, !(v_s5 && lex_less(best_s5[0], red2)))
	`MCC_ASSERT(a_valid_moves, clk, arst_n, en && v_s5 |=> v_s6)
endmodule

// ===== design/mode_coefficient_canonicalizer_core.sv =====
// mode coefficient canonicalizer: six register stages (clamp, gcd, divide, candidates, group minimum,
// final minimum), the last being the output register; one item per clock while the output is not stalled.
// a stall freezes all six stages together and the output register holds its item until taken.
// depth is set by the gcd tree and the 64-way lexicographic minimum tree.
// arst_n clears all valid bits; payload registers are not reset.
// depends on mcc_pkg, mcc_norm, mcc_search
`include "mode_coefficient_canonicalizer_core_defines.svh"
module mode_coefficient_canonicalizer_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata, // re_0, im_0, re_1, im_1, ... im_4, 4 bits each
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [47:0]  m_axis_tdata  // re_0..im_4 4 bits each, common_divisor 3, already_canonical 1, 4 zero bits
);
	import mcc_pkg::*;

	logic en;
	logic nv, sv, same;
	vec_t raw, nc, nraw, best;
	mag_t ng, sg;

	always_comb begin
		for (int i = 0; i < NCOEF; i++) raw[i] = s_axis_tdata[COEFF_BITS*i +: COEFF_BITS];
	end

	// whole pipe advances when the output slot is free or being taken
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	mcc_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(s_axis_tvalid && en), .raw(raw),
		.v_out(nv), .c_out(nc), .raw_out(nraw), .g_out(ng)
	);

	mcc_search u_search (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(nv), .c_in(nc), .raw_in(nraw),
		.g_in(ng), .v_out(sv), .best_out(best), .g_out(sg), .same_out(same)
	);

	assign m_axis_tvalid = sv;
	assign m_axis_tdata = {4'b0, same, sg, best};

	`MCC_ASSERT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	`MCC_ASSERT(a_ready, clk, arst_n, !m_axis_tvalid |-> s_axis_tready)
	`MCC_ASSERT(a_same_gcd, clk, arst_n, m_axis_tvalid && m_axis_tdata[43] |-> m_axis_tdata[42:40] <= 3'd1)
endmodule

// ===== verif/mode_coefficient_canonicalizer_core_tb.sv =====
// testbench for the mode coefficient canonicalizer core: predicts the canonical vector,
// gcd and canonical flag of each item and checks every result in order
// depends on mcc_pkg and mode_coefficient_canonicalizer_core
`timescale 1ns / 100ps
module mode_coefficient_canonicalizer_core_tb;
	import mcc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;

	typedef int coef_vec_t [NCOEF];

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;

	logic [47:0] canon_queue [$];
	int error_count;
	int idle_count;
	bit quiet_phase;
	bit hold_request;

	mode_coefficient_canonicalizer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int to_signed(input logic [3:0] v);
		return v[3] ? int'(v) - 16 : int'(v);
	endfunction

	function automatic int int_gcd(input int a, input int b);
		int t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic void transform(input coef_vec_t c, input int tx, input int ty,
			input bit cj, input bit sw, output coef_vec_t o);
		int kx [NMODES] = '{1, 0, 1, 2, 1};
		int ky [NMODES] = '{0, 1, 1, 1, 2};
		int perm [NMODES] = '{1, 0, 2, 4, 3};
		int src;
		int ph;
		int a;
		int b;
		int ar;
		int br;
		for (int j = 0; j < NMODES; j++) begin
			src = sw ? perm[j] : j;
			ph = (tx * kx[j] + ty * ky[j]) & 3;
			a = c[2 * src];
			b = cj ? -c[2 * src + 1] : c[2 * src + 1];
			case (ph)
				0: begin ar = a; br = b; end
				1: begin ar = b; br = -a; end
				2: begin ar = -a; br = -b; end
				default: begin ar = -b; br = a; end
			endcase
			if (sw) begin
				ar = -ar;
				br = -br;
			end
			o[2 * j] = ar;
			o[2 * j + 1] = br;
		end
	endfunction

	function automatic logic [47:0] canonicalize(input logic [39:0] d);
		coef_vec_t raw;
		coef_vec_t c;
		coef_vec_t best;
		coef_vec_t cand;
		int g;
		bit less;
		bit same;
		logic [47:0] r;
		g = 0;
		for (int i = 0; i < NCOEF; i++) begin
			raw[i] = to_signed(d[4 * i +: 4]);
			c[i] = raw[i] < -CMAX ? -CMAX : raw[i];
			g = int_gcd(g, c[i] < 0 ? -c[i] : c[i]);
		end
		if (g > 1)
			for (int i = 0; i < NCOEF; i++) c[i] = c[i] / g;
		best = c;
		for (int s = 0; s < NSYM; s++) begin
			transform(c, s >> 4, (s >> 2) & 3, s[1], s[0], cand);
			less = 0;
			for (int i = NCOEF - 1; i >= 0; i--)
				if (cand[i] != best[i]) less = cand[i] < best[i];
			if (less) best = cand;
		end
		same = 1;
		for (int i = 0; i < NCOEF; i++) begin
			if (raw[i] != best[i]) same = 0;
			r[4 * i +: 4] = best[i][3:0];
		end
		r[42:40] = g[2:0];
		r[47:43] = {4'b0, same};
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// checker for each accepted result
	always @(posedge clk) begin
		logic [47:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (canon_queue.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				want = canon_queue.pop_front();
				for (int i = 0; i < NCOEF; i++)
					if (m_axis_tdata[4 * i +: 4] !== want[4 * i +: 4])
						report_mismatch($sformatf("coef %0d", i),
							to_signed(m_axis_tdata[4 * i +: 4]),
							to_signed(want[4 * i +: 4]));
				if (m_axis_tdata[42:40] !== want[42:40])
					report_mismatch("common_divisor", m_axis_tdata[42:40], want[42:40]);
				if (m_axis_tdata[43] !== want[43])
					report_mismatch("already_canonical", m_axis_tdata[43], want[43]);
				if (m_axis_tdata[47:44] !== 4'b0)
					report_mismatch("pad bits", m_axis_tdata[47:44], 0);
			end
		end
	end

	// receiver readiness: random stall bursts, or one long hold-off on request
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (200) @(negedge clk);
				hold_request = 0;
				m_axis_tready <= 1'b1;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				m_axis_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_item(input logic [39:0] d);
		int gap;
		if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		canon_queue = {canon_queue, canonicalize(d)};
		@(negedge clk);
	endtask

	function automatic logic [39:0] pack_all(input logic [3:0] v);
		return {NCOEF{v}};
	endfunction

	task automatic test_directed();
		logic [39:0] d;
		logic [47:0] cr;
		send_item('0);
		send_item(pack_all(4'd7));
		send_item(pack_all(4'b1001));
		send_item(pack_all(4'b1000));
		send_item(pack_all(4'd2));
		send_item(pack_all(4'd6));
		send_item(40'h0000000001);
		send_item(40'h0000000010);
		send_item(40'h8000000000);
		send_item(40'h0000000008);
		send_item(40'h7979797979);
		send_item(40'h6363636363);
		send_item(40'h4242424242);
		send_item(40'h1234567012);
		for (int i = 0; i < 8; i++) begin
			d = '0;
			d[4 * (i % NCOEF) +: 4] = 4'($urandom_range(1, 15));
			send_item(d);
		end
		// outputs of the block are canonical: feeding them back must set the flag
		cr = canonicalize(40'h1234567012);
		send_item(cr[39:0]);
	endtask

	function automatic logic [39:0] rand_vec(input bit scaled);
		logic [39:0] d;
		int m;
		m = scaled ? $urandom_range(2, 3) : 1;
		for (int i = 0; i < NCOEF; i++)
			if (scaled) d[4 * i +: 4] = 4'(m * ($urandom_range(0, 4) - 2));
			else if ($urandom_range(0, 3) == 0) d[4 * i +: 4] = '0;
			else d[4 * i +: 4] = 4'($urandom);
		return d;
	endfunction

	task automatic test_random(input int count);
		logic [39:0] d;
		logic [47:0] cr;
		for (int n = 0; n < count; n++) begin
			d = rand_vec($urandom_range(0, 3) == 0);
			// sometimes feed a canonical form back in
			if ($urandom_range(0, 5) == 0) begin
				cr = canonicalize(d);
				d = cr[39:0];
			end
			send_item(d);
		end
	endtask

	task automatic test_backpressure();
		hold_request = 1;
		test_random(100);
	endtask

	task automatic test_full_rate();
		quiet_phase = 1;
		test_random(300);
	endtask

	initial begin
		error_count = 0;
		idle_count = 0;
		quiet_phase = 0;
		hold_request = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1200);
		test_backpressure();
		test_full_rate();
		s_axis_tvalid <= 1'b0;
		while (canon_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
